FILE: rtl/lphi_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe hash insert package
// Shared widths, status codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lphi_pkg;

  localparam int BridgeW = 4;
  localparam int KeyW    = 32;
  localparam int PayW    = 32;
  localparam int StatusW = 2;
  localparam int SlotW   = 6;
  localparam int DigitW  = 4;
  localparam int Digits  = KeyW / DigitW;
  localparam int DigCntW = $clog2(Digits);

  typedef enum logic [StatusW-1:0] {
    StRegistered = 2'd0,
    StDuplicate  = 2'd1,
    StBadBridge  = 2'd2,
    StFull       = 2'd3
  } status_e;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic mod_step;
    logic compare;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic bad_bridge;
    logic hit;
    logic probe_last;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/linear_probe_hash_insert.sv
// ----------------------------------------------------------------------------
// Linear probe hash insert
// Inserts a key and payload handle into one of several open-addressed tables
// with linear probing, and answers with a status code and the slot concerned.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                  Fields
//   in       input      in_valid_i / in_ready_o    bridge_i, key_i, payload_i
//   out      output     out_valid_o / out_ready_i  status_o, slot_o
//
// After reset the key store is cleared one entry a cycle, all BRIDGES *
// TABLE_SIZE entries, and no request is accepted until that pass ends. A
// request is accepted, its key is reduced to the home slot unless TABLE_SIZE
// is a power of two (four key bits a cycle), and each slot probed then takes
// one key store read and compare. An invalid bridge goes straight to the result.
// One request is in work at a time; a finished result waits in the output
// register, and a new request is accepted while it waits.
`default_nettype none

module linear_probe_hash_insert #(
  parameter int TABLE_SIZE = 64,
  parameter int BRIDGES    = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lphi_pkg::BridgeW-1:0]   bridge_i,
  input  logic [lphi_pkg::KeyW-1:0]      key_i,
  input  logic [lphi_pkg::PayW-1:0]      payload_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lphi_pkg::StatusW-1:0]   status_o,
  output logic [lphi_pkg::SlotW-1:0]     slot_o
);

  import lphi_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lphi_controller #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lphi_datapath #(
    .TABLE_SIZE (TABLE_SIZE),
    .BRIDGES    (BRIDGES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .bridge_i  (bridge_i),
    .key_i     (key_i),
    .payload_i (payload_i),
    .status_o  (status_o),
    .slot_o    (slot_o)
  );

endmodule

`default_nettype wire

FILE: rtl/lphi_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read address per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lphi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/lphi_controller.sv
// ----------------------------------------------------------------------------
// Linear probe hash insert controller
// Sequences the clearing pass, the home slot reduction, the probe loop and
// the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lphi_controller #(
  parameter int TABLE_SIZE = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  lphi_pkg::stat_t  stat_i,
  output lphi_pkg::cmd_t   cmd_o
);

  import lphi_pkg::*;

  localparam bit IsPow2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  typedef enum logic [5:0] {
    SClear  = 6'b000001,
    SIdle   = 6'b000010,
    SMod    = 6'b000100,
    SRead   = 6'b001000,
    SCmp    = 6'b010000,
    SResult = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      SClear: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.bad_bridge) begin
            state_d = SResult;
          end else if (IsPow2) begin
            state_d = SRead;
          end else begin
            state_d = SMod;
          end
        end
      end
      SMod: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_last) begin
          state_d = SRead;
        end
      end
      SRead: begin
        state_d = SCmp;
      end
      SCmp: begin
        cmd_o.compare = 1'b1;
        if (stat_i.hit || stat_i.probe_last) begin
          state_d = SResult;
        end else begin
          state_d = SRead;
        end
      end
      SResult: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SClear;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lphi_datapath.sv
// ----------------------------------------------------------------------------
// Linear probe hash insert datapath
// Holds the request, reduces the key to its home slot four bits a cycle,
// walks the key store and keeps the pending and the output result.
// ----------------------------------------------------------------------------
`default_nettype none

module lphi_datapath #(
  parameter int TABLE_SIZE = 64,
  parameter int BRIDGES    = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lphi_pkg::cmd_t                 cmd_i,
  output lphi_pkg::stat_t                stat_o,
  input  logic [lphi_pkg::BridgeW-1:0]   bridge_i,
  input  logic [lphi_pkg::KeyW-1:0]      key_i,
  input  logic [lphi_pkg::PayW-1:0]      payload_i,
  output logic [lphi_pkg::StatusW-1:0]   status_o,
  output logic [lphi_pkg::SlotW-1:0]     slot_o
);

  import lphi_pkg::*;

  localparam int Depth  = BRIDGES * TABLE_SIZE;
  localparam int AW     = $clog2(Depth);
  localparam int IW     = $clog2(TABLE_SIZE);
  localparam int VW     = IW + DigitW;
  localparam bit IsPow2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  logic [KeyW-1:0]    key_q;
  logic [PayW-1:0]    pay_q;
  logic [KeyW-1:0]    kd_q;
  logic [AW-1:0]      base_q;
  logic [IW-1:0]      idx_q, idx_d;
  logic [IW-1:0]      cnt_q, cnt_d;
  logic [DigCntW-1:0] dig_q;
  logic [AW-1:0]      clr_q;
  status_e            res_status_q, res_status_d;
  logic [SlotW-1:0]   res_slot_q, res_slot_d;
  status_e            out_status_q;
  logic [SlotW-1:0]   out_slot_q;

  logic [VW-1:0]      mod_v, mod_sub;
  logic [IW-1:0]      mod_rem;
  logic [AW-1:0]      ram_addr;
  logic [KeyW-1:0]    rd_key;
  logic               key_we, ins_we, match, empty, bad_bridge;

  assign bad_bridge = 5'(bridge_i) >= 5'(BRIDGES);

  assign mod_v = {idx_q, kd_q[KeyW-1 -: DigitW]};

  always_comb begin
    mod_sub = '0;
    for (int m = 1; m < (1 << DigitW); m++) begin
      if (mod_v >= VW'(m * TABLE_SIZE)) begin
        mod_sub = VW'(m * TABLE_SIZE);
      end
    end
  end

  assign mod_rem = IW'(mod_v - mod_sub);

  assign match    = rd_key == key_q;
  assign empty    = rd_key == '0;
  assign ins_we   = cmd_i.compare & ~match & empty;
  assign key_we   = cmd_i.clr_step | ins_we;
  assign ram_addr = cmd_i.clr_step ? clr_q : base_q + AW'(idx_q);

  assign stat_o.clr_last   = clr_q == AW'(Depth - 1);
  assign stat_o.mod_last   = dig_q == DigCntW'(Digits - 1);
  assign stat_o.bad_bridge = bad_bridge;
  assign stat_o.hit        = match | empty;
  assign stat_o.probe_last = cnt_q == IW'(TABLE_SIZE - 1);

  always_comb begin
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    if (cmd_i.accept) begin
      idx_d        = IsPow2 ? IW'(key_i) : '0;
      cnt_d        = '0;
      res_status_d = StBadBridge;
      res_slot_d   = '0;
    end else if (cmd_i.mod_step) begin
      idx_d = mod_rem;
    end else if (cmd_i.compare) begin
      if (match) begin
        res_status_d = StDuplicate;
        res_slot_d   = SlotW'(idx_q);
      end else if (empty) begin
        res_status_d = StRegistered;
        res_slot_d   = SlotW'(idx_q);
      end else begin
        res_status_d = StFull;
        res_slot_d   = '0;
        cnt_d        = cnt_q + 1'b1;
        idx_d        = (idx_q == IW'(TABLE_SIZE - 1)) ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      dig_q <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.accept) begin
        dig_q <= '0;
      end else if (cmd_i.mod_step) begin
        dig_q <= dig_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q  <= key_i;
      pay_q  <= payload_i;
      kd_q   <= key_i;
      base_q <= AW'(32'(bridge_i) * TABLE_SIZE);
    end else if (cmd_i.mod_step) begin
      kd_q <= kd_q << DigitW;
    end
    idx_q        <= idx_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
    end
  end

  lphi_ram #(
    .WIDTH (KeyW),
    .DEPTH (Depth)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .addr_i  (ram_addr),
    .wdata_i (cmd_i.clr_step ? '0 : key_q),
    .rdata_o (rd_key)
  );

  lphi_ram #(
    .WIDTH (PayW),
    .DEPTH (Depth)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (ins_we),
    .addr_i  (ram_addr),
    .wdata_i (pay_q),
    .rdata_o ()
  );

  assign status_o = out_status_q;
  assign slot_o   = out_slot_q;

endmodule

`default_nettype wire

FILE: rtl/lphi_checker.sv
// ----------------------------------------------------------------------------
// Linear probe hash insert checker
// Port-level assertions on the request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module lphi_checker #(
  parameter int BRIDGES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_o,
  input  logic [lphi_pkg::BridgeW-1:0]   bridge_i,
  input  logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  logic [lphi_pkg::StatusW-1:0]   status_o,
  input  logic [lphi_pkg::SlotW-1:0]     slot_o
);

  import lphi_pkg::*;

  logic bad_bridge;

  assign bad_bridge = 5'(bridge_i) >= 5'(BRIDGES);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(slot_o))
    else $error("Result changed or dropped while stalled.");

  a_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StBadBridge || status_o == StFull) |-> slot_o == '0)
    else $error("Nonzero slot reported with a bad bridge or full table.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("A second request was accepted right after the first.");

  a_bad_bridge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && bad_bridge && !out_valid_o
      |=> ##1 out_valid_o && status_o == StBadBridge)
    else $error("Invalid bridge request was not answered as such.");

endmodule

bind linear_probe_hash_insert lphi_checker #(
  .BRIDGES (BRIDGES)
) u_lphi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .bridge_i    (bridge_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .slot_o      (slot_o)
);

`default_nettype wire
